// ----- src/lsk_pkg.sv -----
// ---------------------------------------------------------------------------
// lsk_pkg
// Shared sizes, command codes and the control structs that pass between the
// top level and the diagonal scan engine.
// ---------------------------------------------------------------------------
`default_nettype none

package lsk_pkg;

    // Store depth and the widths that follow from it
    localparam int MAX_LEN = 1024;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int CW      = $clog2(MAX_LEN + 1);

    // Fixed field widths of the interface
    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int LEN_W   = 11;
    localparam int LIM_W   = 11;

    // Width for comparing a count against the mismatch limit
    localparam int CMP_W   = (CW > LIM_W) ? CW : LIM_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FIRST   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECOND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Request from the top level to the scan engine
    typedef struct packed {
        logic             start;
        logic [CW-1:0]    n0;
        logic [CW-1:0]    n1;
        logic [LIM_W-1:0] limit;
    } scan_req_t;

    // Status from the scan engine back to the top level
    typedef struct packed {
        logic          busy;
        logic          done;
        logic [CW-1:0] best;
    } scan_stat_t;

endpackage

`default_nettype wire

// ----- src/lsk_ram.sv -----
// ---------------------------------------------------------------------------
// lsk_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/lsk_scan.sv -----
// ---------------------------------------------------------------------------
// lsk_scan
// Diagonal scan engine: walks every alignment of the two strings with one
// compare unit and a sliding window whose mismatch positions sit in a FIFO.
// ---------------------------------------------------------------------------
`default_nettype none

module lsk_scan (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lsk_pkg::scan_req_t         req,
    output lsk_pkg::scan_stat_t             stat,
    output logic      [lsk_pkg::AW-1:0]     first_raddr,
    output logic      [lsk_pkg::AW-1:0]     second_raddr,
    input  wire logic [lsk_pkg::SYM_W-1:0]  first_rdata,
    input  wire logic [lsk_pkg::SYM_W-1:0]  second_rdata
);

    import lsk_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIAG  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_POPD  = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_NEXTD = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]       state_reg,  state_next;
    logic             phase_reg,  phase_next;
    logic [CW-1:0]    s_reg,      s_next;
    logic [CW-1:0]    ai_reg,     ai_next;
    logic [CW-1:0]    bi_reg,     bi_next;
    logic [CW-1:0]    t_reg,      t_next;
    logic [CW-1:0]    lo_reg,     lo_next;
    logic [CW-1:0]    miss_reg,   miss_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    best_reg,   best_next;
    logic [CW-1:0]    n0_reg,     n0_next;
    logic [CW-1:0]    n1_reg,     n1_next;
    logic [LIM_W-1:0] limit_reg,  limit_next;

    logic             diff;
    logic [CW-1:0]    miss_inc;
    logic [CW-1:0]    win_len;
    logic             last_pos;
    logic             fifo_we;
    logic [AW-1:0]    fifo_q;

    // Mismatch position FIFO: oldest mismatch of the window sits at rd_ptr
    lsk_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_LEN)
    ) u_fifo (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (wr_ptr_reg),
        .wdata (t_reg[AW-1:0]),
        .raddr (rd_ptr_reg),
        .rdata (fifo_q)
    );

    assign first_raddr  = ai_reg[AW-1:0];
    assign second_raddr = bi_reg[AW-1:0];

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_FIN);
    assign stat.best = best_reg;

    // Sequencer and shared compare/add datapath
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        s_next      = s_reg;
        ai_next     = ai_reg;
        bi_next     = bi_reg;
        t_next      = t_reg;
        lo_next     = lo_reg;
        miss_next   = miss_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        best_next   = best_reg;
        n0_next     = n0_reg;
        n1_next     = n1_reg;
        limit_next  = limit_reg;
        fifo_we     = 1'b0;

        diff     = (first_rdata != second_rdata);
        miss_inc = miss_reg + CW'(diff);
        win_len  = t_reg + CW'(1) - lo_reg;
        last_pos = ((ai_reg + CW'(1)) == n0_reg) || ((bi_reg + CW'(1)) == n1_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    n0_next    = req.n0;
                    n1_next    = req.n1;
                    limit_next = req.limit;
                    best_next  = '0;
                    phase_next = 1'b0;
                    s_next     = '0;
                    if ((req.n0 == '0) || (req.n1 == '0))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DIAG;
                    end
                end
            end
            S_DIAG:
            begin
                // Open a fresh window at the head of the diagonal
                ai_next     = phase_reg ? '0 : s_reg;
                bi_next     = phase_reg ? s_reg : '0;
                t_next      = '0;
                lo_next     = '0;
                miss_next   = '0;
                wr_ptr_next = '0;
                rd_ptr_next = '0;
                state_next  = S_RD;
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // Push a mismatch position, slide if over the limit
                miss_next = miss_inc;
                if (diff)
                begin
                    fifo_we     = 1'b1;
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                end
                if (CMP_W'(miss_inc) > CMP_W'(limit_reg))
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_POP:
            begin
                state_next = S_POPD;
            end
            S_POPD:
            begin
                // Drop the oldest mismatch: window starts just past it
                lo_next     = CW'(fifo_q) + CW'(1);
                rd_ptr_next = rd_ptr_reg + AW'(1);
                miss_next   = miss_reg - CW'(1);
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                if (win_len > best_reg)
                begin
                    best_next = win_len;
                end
                t_next     = t_reg + CW'(1);
                ai_next    = ai_reg + CW'(1);
                bi_next    = bi_reg + CW'(1);
                state_next = last_pos ? S_NEXTD : S_RD;
            end
            S_NEXTD:
            begin
                // Advance to the next diagonal, first string offsets then second
                if (!phase_reg)
                begin
                    if ((s_reg + CW'(1)) < n0_reg)
                    begin
                        s_next     = s_reg + CW'(1);
                        state_next = S_DIAG;
                    end
                    else if (n1_reg > CW'(1))
                    begin
                        phase_next = 1'b1;
                        s_next     = CW'(1);
                        state_next = S_DIAG;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    if ((s_reg + CW'(1)) < n1_reg)
                    begin
                        s_next     = s_reg + CW'(1);
                        state_next = S_DIAG;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        ai_reg     <= ai_next;
        bi_reg     <= bi_next;
        t_reg      <= t_next;
        lo_reg     <= lo_next;
        miss_reg   <= miss_next;
        wr_ptr_reg <= wr_ptr_next;
        rd_ptr_reg <= rd_ptr_next;
        best_reg   <= best_next;
        n0_reg     <= n0_next;
        n1_reg     <= n1_next;
        limit_reg  <= limit_next;
    end

endmodule

`default_nettype wire

// ----- src/longest_substring_k_mismatch.sv -----
// ---------------------------------------------------------------------------
// longest_substring_k_mismatch
// Longest common substring of two loaded byte strings with at most a
// configured number of mismatching positions.
// ---------------------------------------------------------------------------
// Command 0 and 1 words append a symbol to the first or second string, one
// word per cycle while the block is ready; symbols beyond 1024 per string are
// dropped and flagged. A command 2 word starts a scan of every diagonal
// alignment; the block is not ready until it ends. Each diagonal opens a new
// window; each aligned position passes read, compare and update states, with
// pop states before the update wherever the window slides. The steps follow
// from the registered read ports of the two string stores and of the mismatch
// position FIFO, which the one compare unit visits in turn. Both strings and
// the overflow flag are cleared on each compute; command 3 is ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module longest_substring_k_mismatch (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [lsk_pkg::LIM_W-1:0]  cfg_write_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [lsk_pkg::CMD_W-1:0]  command,
    input  wire logic [lsk_pkg::SYM_W-1:0]  symbol,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [lsk_pkg::LEN_W-1:0]  best_length,
    output logic                            overflow
);

    import lsk_pkg::*;

    logic [LIM_W-1:0] limit_reg,        limit_next;
    logic [CW-1:0]    first_count_reg,  first_count_next;
    logic [CW-1:0]    second_count_reg, second_count_next;
    logic             dropped_reg,      dropped_next;
    logic             ovf_hold_reg,     ovf_hold_next;
    logic             out_valid_reg,    out_valid_next;
    logic [LEN_W-1:0] out_best_reg,     out_best_next;
    logic             out_ovf_reg,      out_ovf_next;

    logic             accept;
    logic             first_we;
    logic             second_we;
    scan_req_t        req;
    scan_stat_t       stat;
    logic [AW-1:0]    first_raddr;
    logic [AW-1:0]    second_raddr;
    logic [SYM_W-1:0] first_rdata;
    logic [SYM_W-1:0] second_rdata;

    // Take loads while idle; a compute also needs the output register free
    assign in_ready = !stat.busy && !(out_valid_reg && (command == CMD_COMPUTE));
    assign accept   = in_valid && in_ready;

    assign first_we  = accept && (command == CMD_FIRST) &&
                       (first_count_reg < CW'(MAX_LEN));
    assign second_we = accept && (command == CMD_SECOND) &&
                       (second_count_reg < CW'(MAX_LEN));

    assign req.start = accept && (command == CMD_COMPUTE);
    assign req.n0    = first_count_reg;
    assign req.n1    = second_count_reg;
    assign req.limit = limit_reg;

    // String stores
    lsk_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_first (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_count_reg[AW-1:0]),
        .wdata (symbol),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    lsk_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_second (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (symbol),
        .raddr (second_raddr),
        .rdata (second_rdata)
    );

    lsk_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .stat         (stat),
        .first_raddr  (first_raddr),
        .second_raddr (second_raddr),
        .first_rdata  (first_rdata),
        .second_rdata (second_rdata)
    );

    // Load counts, drop flag and the result word
    always_comb
    begin
        limit_next        = limit_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        dropped_next      = dropped_reg;
        ovf_hold_next     = ovf_hold_reg;
        out_valid_next    = out_valid_reg;
        out_best_next     = out_best_reg;
        out_ovf_next      = out_ovf_reg;

        if (cfg_write_en)
        begin
            limit_next = cfg_write_data;
        end

        if (accept)
        begin
            priority if (command == CMD_FIRST)
            begin
                if (first_we)
                begin
                    first_count_next = first_count_reg + CW'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
            else if (command == CMD_SECOND)
            begin
                if (second_we)
                begin
                    second_count_next = second_count_reg + CW'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
            else if (command == CMD_COMPUTE)
            begin
                ovf_hold_next     = dropped_reg;
                first_count_next  = '0;
                second_count_next = '0;
                dropped_next      = 1'b0;
            end
            else
            begin
                dropped_next = dropped_reg;
            end
        end

        // Drop the word once taken, load it when the scan ends
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (stat.done)
        begin
            out_valid_next = 1'b1;
            out_best_next  = LEN_W'(stat.best);
            out_ovf_next   = ovf_hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg        <= '0;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            limit_reg        <= limit_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            dropped_reg      <= dropped_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        ovf_hold_reg <= ovf_hold_next;
        out_best_reg <= out_best_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign best_length = out_best_reg;
    assign overflow    = out_ovf_reg;

endmodule

`default_nettype wire

// ----- src/lsk_checker.sv -----
// ---------------------------------------------------------------------------
// lsk_checker
// Port-level checks on the longest substring block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lsk_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic [lsk_pkg::CMD_W-1:0]  command,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [lsk_pkg::LEN_W-1:0]  best_length,
    input wire logic                       overflow
);

    import lsk_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(best_length) &&
                                       $stable(overflow)))
        else $error("result word changed while stalled");

    // A result never exceeds the store depth
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_length <= LEN_W'(MAX_LEN)))
        else $error("best_length beyond store depth");

    // A compute word closes the input side for at least the next cycle
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == CMD_COMPUTE)) |=> !in_ready)
        else $error("input ready right after compute");

    // Only a compute produces a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command != CMD_COMPUTE) && !out_valid)
            |=> !out_valid)
        else $error("result word without compute");

endmodule

bind longest_substring_k_mismatch lsk_checker u_lsk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .best_length (best_length),
    .overflow    (overflow)
);

`default_nettype wire
